// ----- src/rfd_pkg.sv -----
// Shared constants, types and helpers of the record ring FIFO with tail drop.
package rfd_pkg;

  // Ring geometry
  localparam int unsigned RING_BYTES = 4096;
  localparam int unsigned PTR_W      = $clog2(RING_BYTES);
  localparam int unsigned PTR_X_W    = PTR_W + 1;
  localparam int unsigned CFG_W      = 12;
  // Width that holds both a fill level and a 12-bit register, plus one
  localparam int unsigned CMP_W      = ((PTR_W > CFG_W) ? PTR_W : CFG_W) + 1;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned USED_W     = 12;
  localparam int unsigned DROP_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  // Output tdata width
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [DROP_W-1:0] drop_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_THRESH = 2'd2;

  localparam cfg_t RECORD_BYTES_RST = 12'd128;
  localparam cfg_t CHUNK_THRESH_RST = 12'd512;
  localparam drop_t DROP_MAX        = '1;

  // Status of one command, carried until the read byte leaves the RAM
  typedef struct packed {
    logic               rd_valid;
    logic               taken;
    logic [USED_W-1:0]  used;
    logic               chunk_ready;
    drop_t              dropped;
    logic               overflow;
  } status_t;

  // Fill level from the two ring pointers
  function automatic ptr_t ring_fill(input ptr_t wp, input ptr_t rp);
    logic [PTR_X_W-1:0] diff;
    diff = {1'b0, wp} - {1'b0, rp};
    if (wp < rp) begin
      diff = diff + PTR_X_W'(RING_BYTES);
    end
    return diff[PTR_W-1:0];
  endfunction

  // Advance a ring pointer with wrap
  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(RING_BYTES - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- src/record_ring_fifo_with_drop_unit.sv -----
// Top level of the record ring FIFO with tail drop: control, pointers and output stage.
//
//  Channel      Direction  Handshake               Payload
//  ----------   ---------  ----------------------  ---------------------------------------
//  s_axis       in         tvalid / tready         tuser: cmd, record_start; tdata: byte
//  m_axis       out        tvalid / tready         tuser: read/write flags; tdata: status
//  cfg          in         cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
//  One command per cycle is accepted while the input is not stalled; its result
//  passes the synchronous byte RAM read stage and then the output register.
//  All pointers, counters and record state update at the accepting edge, so the
//  next command sees them at once. A stalled output holds the result; the input
//  stalls only when both the RAM-read stage and the output register are full.
//  Reset clears pointers, counters and flags; the byte store is not cleared.
module record_ring_fifo_with_drop_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  logic [2:0]                      s_axis_tuser,  // [1:0] cmd, [2] record_start

  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] read_data, [19:8] bytes_used, [20] chunk_ready, [36:21] dropped_count,
  // [37] overflow_flag, [39:38] zero
  output logic [rfd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                      m_axis_tuser,  // [0] read_valid, [1] write_taken

  input  logic                            cfg_we_i,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rfd_pkg::CFG_W-1:0]       cfg_wdata_i
);

  // Configuration registers
  logic          enable_q;
  rfd_pkg::cfg_t record_bytes_q;
  rfd_pkg::cfg_t chunk_thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b0;
      record_bytes_q <= rfd_pkg::RECORD_BYTES_RST;
      chunk_thresh_q <= rfd_pkg::CHUNK_THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rfd_pkg::REG_ENABLE:       enable_q       <= cfg_wdata_i[0];
        rfd_pkg::REG_RECORD_BYTES: record_bytes_q <= cfg_wdata_i;
        rfd_pkg::REG_CHUNK_THRESH: chunk_thresh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Ring and record state
  rfd_pkg::ptr_t  wp_q, wp_d;
  rfd_pkg::ptr_t  rp_q, rp_d;
  rfd_pkg::drop_t drop_q, drop_d;
  logic           ovf_q, ovf_d;
  logic           adm_q, adm_d;
  rfd_pkg::cfg_t  left_q, left_d;

  // Output pipeline
  logic                           pend_valid_q, pend_valid_d;
  rfd_pkg::status_t               pend_q, pend_d;
  logic                           out_valid_q, out_valid_d;
  logic [rfd_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [1:0]                     out_user_q;

  logic                  accept;
  logic                  move;
  rfd_pkg::cmd_e         cmd;
  logic [7:0]            in_byte;
  logic                  in_start;

  rfd_pkg::ptr_t         fill_cur;
  rfd_pkg::ptr_t         fill_new;
  logic [rfd_pkg::CMP_W-1:0] space_cur;

  logic                  ram_we;
  logic                  ram_re;
  logic [7:0]            ram_rdata;
  logic [7:0]            rd_byte;

  assign cmd      = rfd_pkg::cmd_e'(s_axis_tuser[1:0]);
  assign in_start = s_axis_tuser[2];
  assign in_byte  = s_axis_tdata;

  // Advance the held result into the output register when it is free or drains
  assign move          = pend_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_valid_q || move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign fill_cur  = rfd_pkg::ring_fill(wp_q, rp_q);
  assign space_cur = rfd_pkg::CMP_W'(rfd_pkg::RING_BYTES - 1)
                   - rfd_pkg::CMP_W'(fill_cur);

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    drop_d = drop_q;
    ovf_d  = ovf_q;
    adm_d  = adm_q;
    left_d = left_q;
    ram_we = 1'b0;
    ram_re = 1'b0;

    if (accept) begin
      unique case (cmd)
        rfd_pkg::CMD_WRITE: begin
          if (enable_q) begin
            // Admit or drop on the first byte of a record
            if (in_start) begin
              if (space_cur >= rfd_pkg::CMP_W'(record_bytes_q)) begin
                adm_d  = 1'b1;
                left_d = record_bytes_q;
              end else begin
                if (drop_q != rfd_pkg::DROP_MAX) begin
                  drop_d = drop_q + 16'd1;
                end
                ovf_d  = 1'b1;
                adm_d  = 1'b0;
                left_d = '0;
              end
            end
            if (adm_d && (left_d != '0) && (space_cur != '0)) begin
              ram_we = 1'b1;
              wp_d   = rfd_pkg::ptr_inc(wp_q);
              left_d = left_d - 12'd1;
            end
            if (left_d == '0) begin
              adm_d = 1'b0;
            end
          end
        end
        rfd_pkg::CMD_READ: begin
          if (fill_cur != '0) begin
            ram_re = 1'b1;
            rp_d   = rfd_pkg::ptr_inc(rp_q);
          end
        end
        rfd_pkg::CMD_CLEAR: begin
          wp_d   = '0;
          rp_d   = '0;
          adm_d  = 1'b0;
          left_d = '0;
        end
        default: ;
      endcase
    end
  end

  assign fill_new = rfd_pkg::ring_fill(wp_d, rp_d);

  // Status after the command; read data joins later from the registered RAM output
  always_comb begin
    pend_d             = pend_q;
    pend_valid_d       = pend_valid_q;
    if (accept) begin
      pend_valid_d       = 1'b1;
      pend_d.rd_valid    = ram_re;
      pend_d.taken       = ram_we;
      pend_d.used        = rfd_pkg::USED_W'(fill_new);
      pend_d.chunk_ready = rfd_pkg::CMP_W'(fill_new) >= rfd_pkg::CMP_W'(chunk_thresh_q);
      pend_d.dropped     = drop_d;
      pend_d.overflow    = ovf_d;
    end else if (move) begin
      pend_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      rp_q         <= '0;
      drop_q       <= '0;
      ovf_q        <= 1'b0;
      adm_q        <= 1'b0;
      left_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      drop_q       <= drop_d;
      ovf_q        <= ovf_d;
      adm_q        <= adm_d;
      left_q       <= left_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Zero the byte unless a read popped one
  assign rd_byte = pend_q.rd_valid ? ram_rdata : 8'd0;

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (move) begin
      out_data_q <= {2'b00, pend_q.overflow, pend_q.dropped, pend_q.chunk_ready,
                     pend_q.used, rd_byte};
      out_user_q <= {pend_q.taken, pend_q.rd_valid};
    end
  end

  // Byte store; its read data holds until the next read, which waits for the stage to move
  rfd_ram #(
    .WIDTH (8),
    .DEPTH (rfd_pkg::RING_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_byte),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- src/rfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
